@@ hw/rtl/hsd_pkg.sv @@
// Shared types, constants and compare functions for the H-bridge slow-decay PWM control block.
package hsd_pkg;

  // Sizing
  localparam int CHANNEL_COUNT = 6;
  localparam int NUM_DRV       = CHANNEL_COUNT / 2;
  localparam int PWM_TOP       = 200;
  localparam int DRV_IDX_W     = (NUM_DRV > 1) ? $clog2(NUM_DRV) : 1;

  // Field widths
  localparam int SPEED_W = 16;
  localparam int CMP_W   = 8;
  localparam int POWER_W = 8;
  localparam int SEL_W   = 2;
  localparam int DP_W    = 2;

  // Reset value of the installed driver count
  localparam logic [DP_W-1:0] DRIVERS_PRESENT_RST = DP_W'(3);

  typedef enum logic [1:0] {
    OP_UPDATE      = 2'd0,
    OP_TEST_START  = 2'd1,
    OP_TEST_STOP   = 2'd2,
    OP_FAULT_CLEAR = 2'd3
  } op_e;

  typedef logic signed [SPEED_W-1:0] speed_t;

  localparam speed_t TOP_S = SPEED_W'(PWM_TOP);

  // One input item
  typedef struct packed {
    op_e                op;
    logic [SEL_W-1:0]   driver_sel;
    logic               channel_sel;
    logic               fault_pin;
    speed_t             speed_a;
    speed_t             speed_b;
    logic [POWER_W-1:0] load_power;
  } item_t;

  // One result item
  typedef struct packed {
    logic             ok;
    logic             sleep_n;
    logic [CMP_W-1:0] cmp_a_fwd;
    logic [CMP_W-1:0] cmp_a_rev;
    logic [CMP_W-1:0] cmp_b_fwd;
    logic [CMP_W-1:0] cmp_b_rev;
    logic             write_a;
    logic             write_b;
    logic             fault_event;
    logic             fault_active;
  } result_t;

  // Forward compare: TOP minus the positive part of the clamped speed
  function automatic logic [CMP_W-1:0] cmp_fwd(speed_t s);
    logic [CMP_W-1:0] r;
    if (s <= 0) begin
      r = CMP_W'(PWM_TOP);
    end else if (s >= TOP_S) begin
      r = '0;
    end else begin
      r = CMP_W'(PWM_TOP) - s[CMP_W-1:0];
    end
    return r;
  endfunction

  // Reverse compare: TOP plus the negative part of the clamped speed
  function automatic logic [CMP_W-1:0] cmp_rev(speed_t s);
    logic [CMP_W-1:0] r;
    if (s >= 0) begin
      r = CMP_W'(PWM_TOP);
    end else if (s <= -TOP_S) begin
      r = '0;
    end else begin
      r = CMP_W'(PWM_TOP) + s[CMP_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/hsd_in_if.sv @@
// Input item channel: valid/ready handshake with the item fields.
interface hsd_in_if;
  logic                        valid;
  logic                        ready;
  hsd_pkg::op_e                op;
  logic [hsd_pkg::SEL_W-1:0]   driver_sel;
  logic                        channel_sel;
  logic                        fault_pin;
  hsd_pkg::speed_t             speed_a;
  hsd_pkg::speed_t             speed_b;
  logic [hsd_pkg::POWER_W-1:0] load_power;

  modport source (
    output valid, op, driver_sel, channel_sel, fault_pin, speed_a, speed_b, load_power,
    input  ready
  );
  modport sink (
    input  valid, op, driver_sel, channel_sel, fault_pin, speed_a, speed_b, load_power,
    output ready
  );
endinterface

@@ hw/rtl/hsd_out_if.sv @@
// Result channel: valid/ready handshake with the result fields.
interface hsd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic                      sleep_n;
  logic [hsd_pkg::CMP_W-1:0] cmp_a_fwd;
  logic [hsd_pkg::CMP_W-1:0] cmp_a_rev;
  logic [hsd_pkg::CMP_W-1:0] cmp_b_fwd;
  logic [hsd_pkg::CMP_W-1:0] cmp_b_rev;
  logic                      write_a;
  logic                      write_b;
  logic                      fault_event;
  logic                      fault_active;

  modport source (
    output valid, ok, sleep_n, cmp_a_fwd, cmp_a_rev, cmp_b_fwd, cmp_b_rev,
           write_a, write_b, fault_event, fault_active,
    input  ready
  );
  modport sink (
    input  valid, ok, sleep_n, cmp_a_fwd, cmp_a_rev, cmp_b_fwd, cmp_b_rev,
           write_a, write_b, fault_event, fault_active,
    output ready
  );
endinterface

@@ hw/rtl/hsd_cfg_if.sv @@
// Configuration write channel for the installed driver count.
interface hsd_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [hsd_pkg::DP_W-1:0] drivers_present;

  modport source (
    output valid, drivers_present,
    input  ready
  );
  modport sink (
    input  valid, drivers_present,
    output ready
  );
endinterface

@@ hw/rtl/hbridge_slow_decay_pwm_control_core.sv @@
// Top level of the H-bridge slow-decay PWM control block.
// Takes one item per cycle unless the result register stalls, and returns
// one result per item: the item waits in the input register, then makes a
// single pass through the driver state logic into the result register. All
// state of the addressed driver is read and written in that one pass, so
// consecutive items see each other's effects with no gap. A stalled result
// register holds the input register; a new item is still taken whenever the
// held one moves on. The driver count register is written over the cfg
// channel, which is always ready; write it only while no item is in flight.
module hbridge_slow_decay_pwm_control_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsd_in_if.sink    in_i,
  hsd_out_if.source out_o,
  hsd_cfg_if.sink   cfg_i
);

  logic                      item_valid;
  hsd_pkg::item_t            item;
  logic                      space;
  logic                      fire;
  hsd_pkg::result_t          result;
  logic [hsd_pkg::DP_W-1:0]  dp_q;

  // Configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_q <= hsd_pkg::DRIVERS_PRESENT_RST;
    end else if (cfg_i.valid) begin
      dp_q <= cfg_i.drivers_present;
    end
  end

  // Item moves from input register to result register
  assign fire = item_valid & space;

  hsd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (fire),
    .valid_o (item_valid),
    .item_o  (item)
  );

  hsd_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (fire),
    .item_i            (item),
    .drivers_present_i (dp_q),
    .result_o          (result)
  );

  hsd_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .result_i (result),
    .space_o  (space),
    .out_o    (out_o)
  );

endmodule

@@ hw/rtl/hsd_in_stage.sv @@
// Input register: captures one item per transfer and holds it until the datapath takes it.
module hsd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  hsd_in_if.sink          in_i,
  input  logic            take_i,
  output logic            valid_o,
  output hsd_pkg::item_t  item_o
);

  logic           valid_q, valid_d;
  hsd_pkg::item_t item_q;
  logic           load;

  // Free slot, or the held item leaves this cycle
  assign in_i.ready = ~valid_q | take_i;
  assign load       = in_i.valid & in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.op          <= in_i.op;
      item_q.driver_sel  <= in_i.driver_sel;
      item_q.channel_sel <= in_i.channel_sel;
      item_q.fault_pin   <= in_i.fault_pin;
      item_q.speed_a     <= in_i.speed_a;
      item_q.speed_b     <= in_i.speed_b;
      item_q.load_power  <= in_i.load_power;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hw/rtl/hsd_datapath.sv @@
// Driver state and single-pass item processing: fault latch, test load, speeds, compares.
module hsd_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  hsd_pkg::item_t            item_i,
  input  logic [hsd_pkg::DP_W-1:0]  drivers_present_i,
  output hsd_pkg::result_t          result_o
);

  typedef struct packed {
    hsd_pkg::speed_t a;
    hsd_pkg::speed_t b;
  } speed_pair_t;

  // Per-driver state, indexed by driver only, plus one test load power shared by all drivers
  logic                          fault_q [hsd_pkg::NUM_DRV];
  logic [1:0]                    ten_q   [hsd_pkg::NUM_DRV];
  speed_pair_t                   last_q  [hsd_pkg::NUM_DRV];
  logic                          sleep_q [hsd_pkg::NUM_DRV];
  logic [hsd_pkg::POWER_W-1:0]   shared_q;

  logic [hsd_pkg::DRV_IDX_W-1:0] d_idx;
  logic                          has_store;

  logic                          fault_d;
  logic [1:0]                    ten_d;
  speed_pair_t                   last_d;
  logic                          sleep_d;
  logic [hsd_pkg::POWER_W-1:0]   shared_d;
  logic                          ok;
  logic                          ev;

  assign d_idx     = hsd_pkg::DRV_IDX_W'(item_i.driver_sel);
  assign has_store = int'(item_i.driver_sel) < hsd_pkg::NUM_DRV;

  // Next state of the addressed driver
  always_comb begin
    logic        en;
    speed_pair_t cur;
    en       = (item_i.op == hsd_pkg::OP_TEST_START);
    cur      = last_q[d_idx];
    fault_d  = fault_q[d_idx];
    ten_d    = ten_q[d_idx];
    last_d   = cur;
    sleep_d  = sleep_q[d_idx];
    shared_d = shared_q;
    ok       = 1'b0;
    ev       = 1'b0;
    unique case (item_i.op)
      hsd_pkg::OP_UPDATE: begin
        ok = 1'b1;
        if (!fault_d && !item_i.fault_pin) begin
          fault_d = 1'b1;
          ev      = 1'b1;
        end
        if (fault_d) begin
          sleep_d  = 1'b0;
          last_d.a = '0;
          last_d.b = '0;
        end else begin
          last_d.a = ten_d[0] ? hsd_pkg::SPEED_W'(shared_q) : item_i.speed_a;
          last_d.b = ten_d[1] ? hsd_pkg::SPEED_W'(shared_q) : item_i.speed_b;
          sleep_d  = (last_d.a != '0) || (last_d.b != '0);
        end
      end
      hsd_pkg::OP_TEST_START, hsd_pkg::OP_TEST_STOP: begin
        if ((item_i.driver_sel < drivers_present_i) && (ten_d[item_i.channel_sel] != en)) begin
          ok                       = 1'b1;
          ten_d[item_i.channel_sel] = en;
          shared_d                 = en ? item_i.load_power : '0;
          sleep_d                  = en;
          if (item_i.channel_sel) begin
            last_d.b = hsd_pkg::SPEED_W'(shared_d);
          end else begin
            last_d.a = hsd_pkg::SPEED_W'(shared_d);
          end
        end
      end
      hsd_pkg::OP_FAULT_CLEAR: begin
        ok      = 1'b1;
        fault_d = 1'b0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    // Result reflects the state after this item; no storage means all zero
    if (has_store) begin
      result_o.ok           = ok;
      result_o.sleep_n      = sleep_d;
      result_o.cmp_a_fwd    = hsd_pkg::cmp_fwd(last_d.a);
      result_o.cmp_a_rev    = hsd_pkg::cmp_rev(last_d.a);
      result_o.cmp_b_fwd    = hsd_pkg::cmp_fwd(last_d.b);
      result_o.cmp_b_rev    = hsd_pkg::cmp_rev(last_d.b);
      result_o.write_a      = (last_d.a != cur.a);
      result_o.write_b      = (last_d.b != cur.b);
      result_o.fault_event  = ev;
      result_o.fault_active = fault_d;
    end else begin
      result_o = '0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hsd_pkg::NUM_DRV; i++) begin
        fault_q[i] <= 1'b0;
        ten_q[i]   <= '0;
        last_q[i]  <= '0;
        sleep_q[i] <= 1'b0;
      end
      shared_q <= '0;
    end else if (fire_i && has_store) begin
      fault_q[d_idx] <= fault_d;
      ten_q[d_idx]   <= ten_d;
      last_q[d_idx]  <= last_d;
      sleep_q[d_idx] <= sleep_d;
      shared_q       <= shared_d;
    end
  end

endmodule

@@ hw/rtl/hsd_out_stage.sv @@
// Result register: holds one result until the sink takes it.
module hsd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hsd_pkg::result_t  result_i,
  output logic              space_o,
  hsd_out_if.source         out_o
);

  logic             valid_q, valid_d;
  hsd_pkg::result_t res_q;

  // Can load when empty or when the held result transfers now
  assign space_o = ~valid_q | out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.ok           = res_q.ok;
  assign out_o.sleep_n      = res_q.sleep_n;
  assign out_o.cmp_a_fwd    = res_q.cmp_a_fwd;
  assign out_o.cmp_a_rev    = res_q.cmp_a_rev;
  assign out_o.cmp_b_fwd    = res_q.cmp_b_fwd;
  assign out_o.cmp_b_rev    = res_q.cmp_b_rev;
  assign out_o.write_a      = res_q.write_a;
  assign out_o.write_b      = res_q.write_b;
  assign out_o.fault_event  = res_q.fault_event;
  assign out_o.fault_active = res_q.fault_active;

endmodule
